### rtl/msdes_pkg.sv
package msdes_pkg;

   // Serial bus phases of the EDID target
   typedef enum logic [2:0] {
      PH_STOP = 3'd0,
      PH_DEV  = 3'd1,
      PH_REG  = 3'd2,
      PH_DATA = 3'd3,
      PH_ACK  = 3'd4
   } msdes_phase_type;

   // Register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      CSR_STD_SENSE  = 2'd0,
      CSR_EXT_SENSE  = 2'd1,
      CSR_DDC_ENABLE = 2'd2,
      CSR_BYTE_COUNT = 2'd3
   } msdes_csr_type;

   localparam int unsigned CSR_AW = 4;

   // Device address match: 0xA0 / 0xA1
   localparam logic [7:0] DEV_MASK  = 8'hFE;
   localparam logic [7:0] DEV_MATCH = 8'hA0;

   // Bit count at which a byte is complete
   localparam logic [3:0] LAST_BIT = 4'd7;

   // Lines grounded by each line: first and second peer
   localparam logic [1:0] PEER_HI [0:2] = '{2'd2, 2'd2, 2'd1};
   localparam logic [1:0] PEER_LO [0:2] = '{2'd1, 2'd0, 2'd0};

   // EDID fetch request from the target to the store
   typedef struct packed {
      logic       en;
      logic [8:0] pos;
   } msdes_fetch_type;

   // Cross grounding: two passes over lines 2 down to 0
   function automatic logic [2:0] msdes_ground(input logic [2:0] lv_i,
                                               input logic [2:0] dirs,
                                               input logic [5:0] ext);
      logic [2:0] lv;
      lv = lv_i;
      for (int pass = 0; pass < 2; pass++) begin
         for (int ln = 2; ln >= 0; ln--) begin
            if (dirs[ln] && !lv[ln]) begin
               if (!ext[2*ln+1]) lv[PEER_HI[ln]] = 1'b0;
               if (!ext[2*ln])   lv[PEER_LO[ln]] = 1'b0;
            end
         end
      end
      return lv;
   endfunction

endpackage

### rtl/msdes_req_if.sv
interface msdes_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [2:0] levels_in;
   logic [2:0] dirs_in;
   logic [7:0] load_addr;
   logic [7:0] load_data;

   modport source (output valid, func, levels_in, dirs_in, load_addr, load_data,
                   input ready);
   modport sink   (input valid, func, levels_in, dirs_in, load_addr, load_data,
                   output ready);
endinterface

### rtl/msdes_rsp_if.sv
interface msdes_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] levels_out;

   modport source (output valid, levels_out, input ready);
   modport sink   (input valid, levels_out, output ready);
endinterface

### rtl/msdes_target.sv
module msdes_target
   import msdes_pkg::*;
#(
   parameter int EDID_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            sda_i,
   input  logic            scl_i,
   input  logic [8:0]      byte_count,
   input  logic [7:0]      rdata,
   output logic            sda_drv,
   output msdes_fetch_type fetch
);

   logic            prev_data_ff, prev_clock_ff;
   msdes_phase_type phase_ff, phase_in;
   msdes_phase_type prior_ff, prior_in;
   logic [3:0]      bitcnt_ff, bitcnt_in;
   logic [7:0]      shift_ff, shift_in, shift_cur;
   logic            pend_ff, pend_zero_ff;
   logic [7:0]      dev_ff, dev_in;
   logic [7:0]      reg_ff, reg_in;
   logic [8:0]      rpos_ff, rpos_in;
   logic            fetch_en, fetch_zero;
   logic [8:0]      fetch_pos;
   logic            data_chg, rise;

   // Shift byte forwarded from the store read issued by the previous transfer
   assign shift_cur = pend_ff ? (pend_zero_ff ? 8'h00 : rdata) : shift_ff;

   assign data_chg = (sda_i != prev_data_ff);
   assign rise     = scl_i && !prev_clock_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      prior_in = prior_ff;
      if (data_chg) begin
         if (scl_i) phase_in = sda_i ? PH_STOP : PH_DEV;
      end else if (rise) begin
         case (phase_ff)
            PH_ACK: begin
               case (prior_ff)
                  PH_DEV:  phase_in = dev_ff[0] ? PH_DATA : PH_REG;
                  PH_REG:  phase_in = PH_DATA;
                  PH_DATA: phase_in = PH_DATA;
                  default: phase_in = phase_ff;
               endcase
            end
            PH_DEV, PH_REG: begin
               if (bitcnt_ff >= LAST_BIT) begin
                  prior_in = phase_ff;
                  phase_in = PH_ACK;
               end
            end
            PH_DATA: begin
               if (bitcnt_ff >= LAST_BIT) begin
                  prior_in = PH_DATA;
                  phase_in = PH_ACK;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Datapath and line drive
   always_comb begin
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_cur;
      dev_in    = dev_ff;
      reg_in    = reg_ff;
      rpos_in   = rpos_ff;
      fetch_en  = 1'b0;
      fetch_pos = rpos_ff;
      sda_drv   = sda_i;
      if (data_chg) begin
         if (scl_i && !sda_i) bitcnt_in = '0;
      end else if (rise) begin
         case (phase_ff)
            PH_ACK: begin
               bitcnt_in = '0;
               shift_in  = '0;
               case (prior_ff)
                  PH_DEV: begin
                     sda_drv = ((dev_ff & DEV_MASK) == DEV_MATCH) ? 1'b0 : 1'b1;
                     if (dev_ff[0]) begin
                        fetch_en  = 1'b1;
                        fetch_pos = '0;
                        rpos_in   = 9'd1;
                     end
                  end
                  PH_REG: sda_drv = (reg_ff == 8'h00) ? 1'b0 : 1'b1;
                  PH_DATA: begin
                     if (dev_ff[0]) begin
                        if (!sda_i && (rpos_ff < byte_count)) begin
                           fetch_en  = 1'b1;
                           fetch_pos = rpos_ff;
                           rpos_in   = rpos_ff + 9'd1;
                        end
                     end else begin
                        sda_drv = 1'b0;
                     end
                  end
                  default: sda_drv = sda_i;
               endcase
            end
            PH_DEV, PH_REG: begin
               shift_in = {shift_cur[6:0], prev_data_ff};
               if (bitcnt_ff >= LAST_BIT) begin
                  bitcnt_in = '0;
                  if (phase_ff == PH_DEV) dev_in = shift_in;
                  else                    reg_in = shift_in;
               end else begin
                  bitcnt_in = bitcnt_ff + 4'd1;
               end
            end
            PH_DATA: begin
               sda_drv = shift_cur[~bitcnt_ff[2:0]];
               if (bitcnt_ff >= LAST_BIT) bitcnt_in = '0;
               else                       bitcnt_in = bitcnt_ff + 4'd1;
            end
            default: bitcnt_in = bitcnt_ff;
         endcase
      end
   end

   // Positions past the count or the store depth read as zero
   assign fetch_zero = !((fetch_pos < byte_count) &&
                         (32'(fetch_pos) < 32'(EDID_DEPTH)));

   assign fetch.en  = step && fetch_en;
   assign fetch.pos = fetch_pos;

   // Target state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_data_ff  <= 1'b0;
         prev_clock_ff <= 1'b0;
         phase_ff      <= PH_STOP;
         prior_ff      <= PH_STOP;
         bitcnt_ff     <= '0;
         shift_ff      <= '0;
         pend_ff       <= 1'b0;
         pend_zero_ff  <= 1'b0;
         dev_ff        <= '0;
         reg_ff        <= '0;
         rpos_ff       <= '0;
      end else if (step) begin
         prev_data_ff  <= sda_drv;
         prev_clock_ff <= scl_i;
         phase_ff      <= phase_in;
         prior_ff      <= prior_in;
         bitcnt_ff     <= bitcnt_in;
         shift_ff      <= shift_in;
         pend_ff       <= fetch_en;
         pend_zero_ff  <= fetch_zero;
         dev_ff        <= dev_in;
         reg_ff        <= reg_in;
         rpos_ff       <= rpos_in;
      end
   end

endmodule

### rtl/monitor_sense_ddc_edid_slave.sv
// A pin sample's levels appear on the result channel in the cycle after its transfer.
// Throughput: one item per cycle unless the result channel stalls. An EDID byte read from
// the store's single read port lands in the next cycle and feeds the target's shift byte.
// Load items give no result and write the store in the cycle of their transfer.
// Reset (synchronous, active high) clears registers, target state and the output stage;
// the EDID store keeps its contents and is undefined until loaded.
module monitor_sense_ddc_edid_slave
   import msdes_pkg::*;
#(
   parameter int EDID_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   msdes_req_if.sink           req_ch,
   msdes_rsp_if.source         rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int AW = $clog2(EDID_DEPTH);

   logic [2:0]      std_ff;
   logic [5:0]      ext_ff;
   logic            ddc_ff;
   logic [8:0]      count_ff;
   logic            rsp_valid_ff;
   logic [2:0]      levels_ff;
   logic [7:0]      rdata_ff;
   logic [7:0]      edid_mem [EDID_DEPTH];
   logic            req_acc, sample_acc, load_acc, step;
   logic [2:0]      lv_host, lv_sense, lv_merge, lv_result;
   logic            sda_drv;
   msdes_fetch_type fetch;
   logic [AW-1:0]   rd_addr, wr_addr;
   msdes_csr_type   csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = msdes_csr_type'(paddr[3:2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         std_ff   <= 3'd7;
         ext_ff   <= 6'd63;
         ddc_ff   <= 1'b0;
         count_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (csr_idx)
            CSR_STD_SENSE:  std_ff   <= pwdata[2:0];
            CSR_EXT_SENSE:  ext_ff   <= pwdata[5:0];
            CSR_DDC_ENABLE: ddc_ff   <= pwdata[0];
            CSR_BYTE_COUNT: count_ff <= pwdata[8:0];
            default:        std_ff   <= std_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_idx)
         CSR_STD_SENSE:  prdata = {29'd0, std_ff};
         CSR_EXT_SENSE:  prdata = {26'd0, ext_ff};
         CSR_DDC_ENABLE: prdata = {31'd0, ddc_ff};
         CSR_BYTE_COUNT: prdata = {23'd0, count_ff};
         default:        prdata = '0;
      endcase
   end

   // Handshake: output register frees the input side
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign sample_acc   = req_acc && !req_ch.func;
   assign load_acc     = req_acc && req_ch.func;
   assign step         = sample_acc && ddc_ff;

   // First sense pass
   assign lv_host  = ((~req_ch.dirs_in) | (req_ch.dirs_in & req_ch.levels_in)) & std_ff;
   assign lv_sense = msdes_ground(lv_host, req_ch.dirs_in, ext_ff);

   msdes_target #(.EDID_DEPTH(EDID_DEPTH)) u_target (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .sda_i      (lv_sense[2]),
      .scl_i      (lv_sense[1]),
      .byte_count (count_ff),
      .rdata      (rdata_ff),
      .sda_drv    (sda_drv),
      .fetch      (fetch)
   );

   // Merge the target's drive, then sense again
   assign lv_merge  = lv_sense & {sda_drv, lv_sense[1], 1'b1} & std_ff;
   assign lv_result = ddc_ff ? msdes_ground(lv_merge, req_ch.dirs_in, ext_ff) : lv_sense;

   // EDID store: one write port for loads, one registered read port for fetches
   assign rd_addr = AW'(32'(fetch.pos));
   assign wr_addr = AW'(32'(req_ch.load_addr));

   always_ff @(posedge clock) begin
      if (load_acc && (32'(req_ch.load_addr) < 32'(EDID_DEPTH))) begin
         edid_mem[wr_addr] <= req_ch.load_data;
      end
      if (fetch.en) begin
         rdata_ff <= edid_mem[rd_addr];
      end
   end

   // Output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= sample_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) levels_ff <= lv_result;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.levels_out = levels_ff;

endmodule

### rtl/msdes_checker.sv
module msdes_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_func,
   input logic [2:0] req_levels,
   input logic [2:0] req_dirs,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_levels
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_levels)))
      else $error("stalled result changed");

   // Every pin sample gives a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_func) |=> rsp_valid)
      else $error("pin sample lost its result");

   // A load gives no result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
      else $error("load produced a result");

   // A line the host drives low always reads low
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_func) |=>
         ((rsp_levels & $past(req_dirs & ~req_levels)) == 3'b000))
      else $error("driven low line read high");

endmodule

bind monitor_sense_ddc_edid_slave msdes_checker u_msdes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_func   (req_ch.func),
   .req_levels (req_ch.levels_in),
   .req_dirs   (req_ch.dirs_in),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_levels (rsp_ch.levels_out)
);

### sim/msdes_tb_pkg.sv
package msdes_tb_pkg;

   // Item kinds on the input channel
   localparam logic FUNC_PIN  = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Serial EDID device addresses, write and read
   localparam logic [7:0] EDID_DEV_WRITE = 8'hA0;
   localparam logic [7:0] EDID_DEV_READ  = 8'hA1;

endpackage

### sim/msdes_sense_checker.sv
module msdes_sense_checker
   import msdes_pkg::*;
   import msdes_tb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   msdes_req_if              req_mon,
   msdes_rsp_if              rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output int                mismatches,
   output int                levels_owed
);

   localparam int         STORE_DEPTH = 256;
   localparam logic [7:0] RW_BIT_MASK = 8'hFE;

   // Register copies
   logic [2:0] std_code;
   logic [5:0] ext_code;
   logic       ddc_on;
   logic [8:0] byte_count;

   // Serial target copy
   logic            sda_last;
   logic            scl_last;
   msdes_phase_type phase;
   msdes_phase_type phase_before;
   logic [3:0]      bit_cnt;
   logic [7:0]      shreg;
   logic [7:0]      dev_byte;
   logic [7:0]      offset_byte;
   logic [8:0]      rd_pos;
   logic [7:0]      edid_mem [STORE_DEPTH];

   logic [2:0] levels_due [$];
   int         fail_cnt = 0;

   task automatic report_mismatch(string msg);
      $display("levels check: %s", msg);
      fail_cnt++;
   endtask

   // Cross grounding, two passes over lines 2 down to 0
   function automatic logic [2:0] cross_ground(logic [2:0] lv_in, logic [2:0] dirs);
      logic [2:0] lv;
      int         first_peer;
      int         second_peer;
      lv = lv_in;
      repeat (2) begin
         for (int ln = 2; ln >= 0; ln--) begin
            // line 0 pulls 2 and 1, line 1 pulls 2 and 0, line 2 pulls 1 and 0
            first_peer  = (ln == 2) ? 1 : 2;
            second_peer = (ln == 0) ? 1 : 0;
            if (dirs[ln] && !lv[ln]) begin
               if (!ext_code[2*ln+1]) lv[first_peer] = 1'b0;
               if (!ext_code[2*ln])   lv[second_peer] = 1'b0;
            end
         end
      end
      return lv;
   endfunction

   function automatic logic [7:0] edid_byte(logic [8:0] pos);
      if (pos < byte_count && pos < STORE_DEPTH) return edid_mem[pos[7:0]];
      return 8'h00;
   endfunction

   // One sample of the serial target; returns the AND mask for the lines
   function automatic logic [2:0] ddc_step(logic sda_in, logic scl_in);
      logic sda;
      logic rise;
      sda  = sda_in;
      rise = 1'b0;
      if (scl_in != scl_last) begin
         scl_last = scl_in;
         rise     = scl_in;
      end
      if (sda != sda_last) begin
         // data moving under a high clock: start or stop
         if (scl_last) begin
            if (!sda) begin
               phase   = PH_DEV;
               bit_cnt = '0;
            end else begin
               phase = PH_STOP;
            end
         end
      end else if (rise) begin
         case (phase)
            PH_ACK: begin
               bit_cnt = '0;
               shreg   = '0;
               if (phase_before == PH_DEV) begin
                  sda = ((dev_byte & RW_BIT_MASK) == EDID_DEV_WRITE) ? 1'b0 : 1'b1;
                  if (dev_byte[0]) begin
                     phase  = PH_DATA;
                     shreg  = edid_byte(9'd0);
                     rd_pos = 9'd1;
                  end else begin
                     phase = PH_REG;
                  end
               end else if (phase_before == PH_REG) begin
                  phase = PH_DATA;
                  sda   = (offset_byte == 8'h00) ? 1'b0 : 1'b1;
               end else if (phase_before == PH_DATA) begin
                  phase = PH_DATA;
                  if (dev_byte[0]) begin
                     // host ack fetches the next byte; position saturates at the count
                     if (!sda) begin
                        if (rd_pos < byte_count) begin
                           shreg  = edid_byte(rd_pos);
                           rd_pos = rd_pos + 9'd1;
                        end else begin
                           shreg = '0;
                        end
                     end
                  end else begin
                     sda = 1'b0;
                  end
               end
            end
            PH_DEV, PH_REG: begin
               // shifts in the level the target left on the line
               shreg = {shreg[6:0], sda_last};
               if (bit_cnt >= 4'd7) begin
                  bit_cnt      = '0;
                  phase_before = phase;
                  phase        = PH_ACK;
                  if (phase_before == PH_DEV) dev_byte = shreg;
                  else offset_byte = shreg;
               end else begin
                  bit_cnt++;
               end
            end
            PH_DATA: begin
               sda = shreg[3'd7 - bit_cnt[2:0]];
               if (bit_cnt >= 4'd7) begin
                  bit_cnt      = '0;
                  phase_before = PH_DATA;
                  phase        = PH_ACK;
               end else begin
                  bit_cnt++;
               end
            end
            default: ;
         endcase
      end
      sda_last = sda;
      scl_last = scl_in;
      return {sda, scl_in, 1'b1};
   endfunction

   function automatic logic [2:0] predict_levels(logic [2:0] lv_in, logic [2:0] dirs);
      logic [2:0] lv;
      logic [2:0] drv;
      lv = (~dirs | (dirs & lv_in)) & std_code;
      lv = cross_ground(lv, dirs);
      if (ddc_on) begin
         drv = ddc_step(lv[2], lv[1]);
         lv  = cross_ground(lv & drv & std_code, dirs);
      end
      return lv;
   endfunction

   always @(posedge clock) begin
      logic [2:0] want;
      if (reset) begin
         std_code     = 3'd7;
         ext_code     = 6'h3F;
         ddc_on       = 1'b0;
         byte_count   = '0;
         sda_last     = 1'b0;
         scl_last     = 1'b0;
         phase        = PH_STOP;
         phase_before = PH_STOP;
         bit_cnt      = '0;
         shreg        = '0;
         dev_byte     = '0;
         offset_byte  = '0;
         rd_pos       = '0;
         levels_due.delete();
      end else begin
         // result transfer against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (levels_due.size() == 0) begin
               report_mismatch($sformatf("levels_out %b with nothing expected",
                                         rsp_mon.levels_out));
            end else begin
               want = levels_due.pop_front();
               if (rsp_mon.levels_out !== want)
                  report_mismatch($sformatf("levels_out %b, expected %b",
                                            rsp_mon.levels_out, want));
            end
         end
         // register write
         if (psel && penable && pwrite && pready) begin
            case (msdes_csr_type'(paddr[CSR_AW-1:2]))
               CSR_STD_SENSE:  std_code   = pwdata[2:0];
               CSR_EXT_SENSE:  ext_code   = pwdata[5:0];
               CSR_DDC_ENABLE: ddc_on     = pwdata[0];
               CSR_BYTE_COUNT: byte_count = pwdata[8:0];
               default: ;
            endcase
         end
         // input transfer
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_LOAD)
               edid_mem[req_mon.load_addr] = req_mon.load_data;
            else
               levels_due.push_back(predict_levels(req_mon.levels_in, req_mon.dirs_in));
         end
      end
      levels_owed <= levels_due.size();
      mismatches  <= fail_cnt;
   end

endmodule

### sim/monitor_sense_ddc_edid_slave_tb.sv
module monitor_sense_ddc_edid_slave_tb;
   import msdes_pkg::*;
   import msdes_tb_pkg::*;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                mismatches;
   int                levels_owed;

   msdes_req_if req_bus ();
   msdes_rsp_if rsp_bus ();

   // Stimulus shaping
   bit   send_lazy = 1'b0;
   bit   recv_lazy = 1'b0;
   bit   squeeze   = 1'b0;
   bit   squeezed  = 1'b0;
   bit   written [256];
   logic ddc_on    = 1'b0;
   int   items_sent = 0;

   monitor_sense_ddc_edid_slave dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   msdes_sense_checker levels_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .levels_owed (levels_owed)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // One item on the input channel, held until its transfer
   task automatic send_item(logic f, logic [2:0] lv, logic [2:0] dr,
                            logic [7:0] a, logic [7:0] d);
      int gap;
      gap = send_lazy ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= f;
      req_bus.levels_in <= lv;
      req_bus.dirs_in   <= dr;
      req_bus.load_addr <= a;
      req_bus.load_data <= d;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic pin_sample(logic [2:0] lv, logic [2:0] dr);
      send_item(FUNC_PIN, lv, dr, 8'($urandom), 8'($urandom));
   endtask

   task automatic load_byte(logic [7:0] a, logic [7:0] d);
      send_item(FUNC_LOAD, 3'($urandom), 3'($urandom), a, d);
      written[a] = 1'b1;
   endtask

   // Drain the result channel, then allow for a load still in flight
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (levels_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(msdes_csr_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_DDC_ENABLE) ddc_on = value[0];
   endtask

   task automatic apply_setup(logic [31:0] std_v, logic [31:0] ext_v,
                              logic [31:0] ddc_v, logic [31:0] count_v);
      csr_write(CSR_STD_SENSE, std_v);
      csr_write(CSR_EXT_SENSE, ext_v);
      csr_write(CSR_DDC_ENABLE, ddc_v);
      csr_write(CSR_BYTE_COUNT, count_v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Entries loaded contiguously from address 0
   function automatic int filled_prefix();
      int n;
      n = 0;
      while (n < 256 && written[n]) n++;
      return n;
   endfunction

   // Host side of the serial bus: low is a driven zero, high is released or driven
   task automatic drive_bus(logic scl, logic sda);
      logic [2:0] lv;
      logic [2:0] dr;
      logic [2:0] want;
      lv   = 3'($urandom);
      dr   = 3'($urandom);
      want = {sda, scl, 1'b0};
      if ($urandom_range(0, 4) != 0) dr[0] = 1'b0;
      for (int ln = 1; ln <= 2; ln++) begin
         if (!want[ln]) begin
            dr[ln] = 1'b1;
            lv[ln] = 1'b0;
         end else if ($urandom_range(0, 1)) begin
            dr[ln] = 1'b0;
         end else begin
            dr[ln] = 1'b1;
            lv[ln] = 1'b1;
         end
      end
      if ($urandom_range(0, 29) == 0) load_byte(8'($urandom), 8'($urandom));
      pin_sample(lv, dr);
   endtask

   task automatic host_bit(logic b);
      drive_bus(1'b0, b);
      drive_bus(1'b1, b);
   endtask

   task automatic host_byte(logic [7:0] b);
      for (int i = 7; i >= 0; i--) host_bit(b[i]);
   endtask

   // Start, device address, then register write or EDID read, then stop unless left open
   task automatic bus_transaction();
      logic [7:0] dev;
      logic [7:0] reg_sel;
      int         nbytes;
      int         roll;
      drive_bus(1'b0, 1'b1);
      drive_bus(1'b1, 1'b1);
      drive_bus(1'b1, 1'b0);
      roll = $urandom_range(0, 19);
      dev  = (roll < 10) ? EDID_DEV_READ : ((roll < 17) ? EDID_DEV_WRITE : 8'($urandom));
      host_byte(dev);
      host_bit(1'b1);
      // broken transfer: abandoned after the address
      if ($urandom_range(0, 9) == 0) return;
      if (dev[0]) begin
         nbytes = $urandom_range(1, 6);
         for (int k = 0; k < nbytes; k++) begin
            repeat (8) host_bit(1'b1);
            // host acks all but the last byte, and now and then refuses early
            host_bit((k == nbytes - 1) || ($urandom_range(0, 9) == 0));
         end
      end else begin
         reg_sel = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00;
         host_byte(reg_sel);
         host_bit(1'b1);
         nbytes = $urandom_range(0, 2);
         for (int k = 0; k < nbytes; k++) begin
            host_byte(8'($urandom));
            host_bit(1'b1);
         end
      end
      // stop, or leave the bus open for a repeated start
      if ($urandom_range(0, 3) != 0) begin
         drive_bus(1'b0, 1'b0);
         drive_bus(1'b1, 1'b0);
         drive_bus(1'b1, 1'b1);
      end
   endtask

   // Result side: random stalls, plus one long hold to back the block up
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (squeeze && !squeezed) begin
            rsp_bus.ready <= 1'b0;
            repeat (150) @(posedge clock);
            squeezed = 1'b1;
            stall    = 0;
         end else begin
            stall = recv_lazy ? $urandom_range(0, 13) : 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   initial begin
      int fill_next;
      int start_count;
      int pick;
      int prefix;
      int count_v;
      fill_next = 0;
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.func      <= FUNC_PIN;
      req_bus.levels_in <= '0;
      req_bus.dirs_in   <= '0;
      req_bus.load_addr <= '0;
      req_bus.load_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: released, fully driven and mixed lines, store extremes
      pin_sample(3'b000, 3'b000);
      pin_sample(3'b111, 3'b000);
      pin_sample(3'b000, 3'b111);
      pin_sample(3'b111, 3'b111);
      pin_sample(3'b101, 3'b010);
      load_byte(8'h00, 8'hFF);
      load_byte(8'hFF, 8'h00);
      load_byte(8'hAA, 8'h55);

      // All lines grounded by the standard code, full cross connection
      drain();
      apply_setup(0, 0, 0, 0);
      pin_sample(3'b111, 3'b111);
      pin_sample(3'b000, 3'b101);

      // Each line driven low in turn pulls its peers
      drain();
      apply_setup(7, 0, 0, 0);
      pin_sample(3'b110, 3'b001);
      pin_sample(3'b101, 3'b010);
      pin_sample(3'b011, 3'b100);
      pin_sample(3'b110, 3'b111);

      // Only the first or only the second peer connected
      drain();
      apply_setup(7, 6'b101010, 0, 0);
      pin_sample(3'b110, 3'b001);
      pin_sample(3'b011, 3'b100);
      drain();
      apply_setup(7, 6'b010101, 0, 0);
      pin_sample(3'b110, 3'b001);
      pin_sample(3'b101, 3'b010);

      // Serial target on: idle bus, then a start
      drain();
      apply_setup(7, 63, 1, 1);
      pin_sample(3'b111, 3'b111);
      pin_sample(3'b011, 3'b111);
      pin_sample(3'b001, 3'b111);

      // Random phases, each under its own settings
      for (int ph = 0; ph < 14; ph++) begin
         drain();
         send_lazy = ($urandom_range(0, 3) != 0) && (ph != 7);
         recv_lazy = ($urandom_range(0, 3) != 0);
         prefix = filled_prefix();
         if (ph == 12) count_v = prefix;
         else if (ph == 13) count_v = 0;
         else begin
            case ($urandom_range(0, 2))
               0:       count_v = prefix;
               1:       count_v = $urandom_range(0, prefix);
               default: count_v = $urandom_range(0, (prefix < 8) ? prefix : 8);
            endcase
         end
         apply_setup((ph == 1) ? 0 : ((ph == 3) ? $urandom_range(0, 7) : 7),
                     (ph == 2) ? 0 : ((ph % 4 == 3) ? $urandom_range(0, 63) : 63),
                     (ph == 0 || ph == 4 || ph == 9) ? 0 : 1,
                     count_v);
         squeeze = (ph == 7);
         // keep filling the store from address 0 upward
         repeat (48) begin
            if (fill_next < 256) begin
               load_byte(8'(fill_next), 8'($urandom));
               fill_next++;
            end
         end
         start_count = items_sent;
         while (items_sent - start_count < 40) begin
            pick = $urandom_range(0, 9);
            if (ddc_on && pick < 6) bus_transaction();
            else if (pick < 8) pin_sample(3'($urandom), 3'($urandom));
            else load_byte(8'($urandom), 8'($urandom));
         end
      end

      drain();
      if (mismatches == 0 && levels_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
